// ===== hw/rtl/zpc_pkg.sv =====
// zpc_pkg: shared widths, register indexes, reset values and signal codes
// for the z-score peak counter. No dependencies.

package zpc_pkg;

    // Default structural parameters
    localparam int LAG_DEFAULT         = 5;
    localparam int MAX_SAMPLES_DEFAULT = 1024;

    // Field widths
    localparam int SAMPLE_W    = 16;
    localparam int TALLY_W     = 10;
    localparam int THR_W       = 8;
    localparam int INFL_W      = 9;
    localparam int MDEV_W      = 15;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int OUT_TDATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INFLUENCE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DEV   = 2'd2;

    // Configuration reset values
    localparam logic [THR_W-1:0]  THR_RESET  = 8'd56;
    localparam logic [INFL_W-1:0] INFL_RESET = 9'd128;
    localparam logic [MDEV_W-1:0] MDEV_RESET = 15'd102;

    // Influence is full weight at 1.0 in Q1.8
    localparam logic [INFL_W-1:0] INFL_MAX = 9'd256;

    // Tally saturation
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    // Signal codes of the previous sample
    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_POS  = 2'd1;
    localparam logic [1:0] SIG_NEG  = 2'd3;

endpackage

// ===== hw/rtl/zpc_mul.sv =====
// zpc_mul: shared signed multiplier with a registered product and a hold
// enable. No package dependencies.

module zpc_mul #(
    parameter int MW = 24
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [MW-1:0]   a,
    input  logic signed [MW-1:0]   b,
    output logic signed [2*MW-1:0] p
);

    logic signed [2*MW-1:0] prod_reg;

    // Product register; holds while en is low
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign p = prod_reg;

endmodule

// ===== hw/rtl/zpc_hist.sv =====
// zpc_hist: filtered history of the z-score peak counter, a shift line of
// DEPTH samples with one selectable read tap. Depends on zpc_pkg.

module zpc_hist
    import zpc_pkg::*;
#(
    parameter int DEPTH = LAG_DEFAULT + 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         clr,
    input  logic signed [SAMPLE_W-1:0]   din,
    input  logic [$clog2(DEPTH)-1:0]     rd_idx,
    output logic signed [SAMPLE_W-1:0]   rd_data,
    output logic signed [SAMPLE_W-1:0]   newest
);

    logic signed [SAMPLE_W-1:0] hist_reg [DEPTH];

    // Newest value enters at entry 0; clear wins over push
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (clr)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            hist_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    assign rd_data = hist_reg[rd_idx];
    assign newest  = hist_reg[0];

endmodule

// ===== hw/rtl/zscore_peak_counter_unit.sv =====
// zscore_peak_counter_unit: top level of the z-score peak counter.
// Uses zpc_pkg, zpc_hist (filtered history) and zpc_mul (shared multiplier).
//
// Usage:
//   Samples enter on the s_axis channel, one signed Q5.10 sample per
//   transaction, tlast on the final sample of a window. After the last
//   sample one result leaves on m_axis: the peak count in tdata and the
//   short-window error flag in tuser. Other samples give no result.
//   Configuration registers (threshold, influence, minimum deviation): the user
//   writes them at cfg index 0, 1, 2 while idle; the block does not enforce it.
// Timing:
//   All arithmetic goes through one registered multiplier under a state
//   sequencer. The first LAG samples of a window are only pushed into the
//   history. Later samples take a sum and sum of squares over LAG history
//   entries, then five multiplies for the variance test and two for the
//   filter update, the second of these only when the sample is a signal.
//   The result is registered when the last sample of a window commits.
// Reset and stalls:
//   Reset clears the window state and loads the default configuration.
//   A result waits in the output register; the next sample is still taken,
//   and only a further window end stalls until the result is taken.

module zscore_peak_counter_unit
    import zpc_pkg::*;
#(
    parameter int LAG         = LAG_DEFAULT,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Sample stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] sample
    input  logic                   s_axis_tlast,   // last
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [9:0] peak_count, [15:10] zero
    output logic                   m_axis_tuser,   // [0] window_error
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Derived widths
    localparam int LAGW = $clog2(LAG + 1);
    localparam int IMAX = (MAX_SAMPLES > LAG + 1) ? MAX_SAMPLES : LAG + 1;
    localparam int IW   = $clog2(IMAX + 1);
    localparam int SUMW = SAMPLE_W + LAGW;
    localparam int SQW  = 2 * SAMPLE_W - 1;
    localparam int QW   = SQW + LAGW;
    localparam int DW   = SAMPLE_W + LAGW + 1;
    localparam int VW   = QW + LAGW;
    localparam int HW   = (VW + 1) / 2;
    localparam int T2W  = 2 * THR_W;
    localparam int MW0  = (DW > HW + 1) ? DW : HW + 1;
    localparam int MW   = (MW0 > T2W + 1) ? MW0 : T2W + 1;
    localparam int PW   = 2 * MW;
    localparam int RW   = T2W + VW;
    localparam int LW   = 2 * (DW - 1) + 8;
    localparam int CW   = (RW > LW) ? RW : LW;
    localparam int MXW  = SAMPLE_W + INFL_W;

    localparam logic signed [DW-1:0] LAG_D = DW'(LAG);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_SQ_S,
        ST_SQ_T,
        ST_SQ_D,
        ST_R_LO,
        ST_R_HI,
        ST_DECIDE,
        ST_MIX,
        ST_PUSH
    } state_t;

    state_t                    state_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                      last_reg;
    logic [LAGW-1:0]           off_reg;
    logic [LAGW-1:0]           k_reg;
    logic signed [SUMW-1:0]    s_acc_reg;
    logic [QW-1:0]             q_acc_reg;
    logic signed [DW-1:0]      d_reg;
    logic [VW-1:0]             v_reg;
    logic [T2W-1:0]            t2_reg;
    logic [CW-1:0]             lhs_reg;
    logic [CW-1:0]             rhs_reg;
    logic signed [MXW-1:0]     mix_reg;
    logic [1:0]                sig_reg;
    logic [1:0]                prev_sig_reg;
    logic [TALLY_W-1:0]        tally_reg;
    logic [IW-1:0]             idx_reg;
    logic                      m_valid_reg;
    logic [TALLY_W-1:0]        m_count_reg;
    logic                      m_err_reg;
    logic [THR_W-1:0]          thr_reg;
    logic [INFL_W-1:0]         infl_reg;
    logic [MDEV_W-1:0]         mdev_reg;

    logic                      s_fire;
    logic [LAGW-1:0]           rd_idx;
    logic signed [SAMPLE_W-1:0] hist_rd;
    logic signed [SAMPLE_W-1:0] hist_newest;
    logic                      mul_en;
    logic signed [MW-1:0]      mul_a;
    logic signed [MW-1:0]      mul_b;
    logic signed [PW-1:0]      prod;

    logic signed [DW-1:0]      lagx;
    logic [VW-1:0]             lagq;
    logic signed [VW:0]        v_diff;
    logic [VW-1:0]             v_clamp;
    logic [DW-1:0]             d_abs;
    logic [DW-2:0]             ad;
    logic [DW-2:0]             lagmin;
    logic [CW-1:0]             rhs_full;
    logic                      sig_hit;
    logic [INFL_W-1:0]         infl_eff;
    logic [INFL_W-1:0]         infl_cmp;
    logic signed [MXW-1:0]     mix_sum;
    logic signed [SAMPLE_W-1:0] newval;
    logic                      push_go;
    logic                      hist_push;
    logic                      hist_clr;
    logic [TALLY_W-1:0]        tally_next;
    logic                      win_err;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            infl_reg <= INFL_RESET;
            mdev_reg <= MDEV_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                CFG_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                CFG_INFLUENCE: infl_reg <= cfg_data[INFL_W-1:0];
                CFG_MIN_DEV:   mdev_reg <= cfg_data[MDEV_W-1:0];
                default:       ;
            endcase
        end
    end

    // History and shared multiplier
    assign rd_idx = off_reg + k_reg;

    zpc_hist #(
        .DEPTH (LAG + 1)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (hist_push),
        .clr     (hist_clr),
        .din     (newval),
        .rd_idx  (rd_idx),
        .rd_data (hist_rd),
        .newest  (hist_newest)
    );

    zpc_mul #(
        .MW (MW)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // Datapath terms around the multiplier
    assign lagx     = LAG_D * DW'(x_reg);
    assign lagq     = VW'(LAG) * VW'(q_acc_reg);
    assign v_diff   = $signed({1'b0, lagq}) - $signed({1'b0, prod[VW-1:0]});
    assign v_clamp  = v_diff[VW] ? '0 : v_diff[VW-1:0];
    assign d_abs    = d_reg[DW-1] ? $unsigned(-d_reg) : $unsigned(d_reg);
    assign ad       = d_abs[DW-2:0];
    assign lagmin   = (DW-1)'(LAG) * (DW-1)'(mdev_reg);
    assign rhs_full = rhs_reg + (CW'(prod[T2W+(VW-HW)-1:0]) << HW);
    assign sig_hit  = (ad > lagmin) && (lhs_reg > rhs_full);
    assign infl_eff = (infl_reg > INFL_MAX) ? INFL_MAX : infl_reg;
    assign infl_cmp = INFL_MAX - infl_eff;
    assign mix_sum  = mix_reg + $signed(prod[MXW-1:0]);
    assign newval   = (sig_reg == SIG_NONE) ? x_reg : mix_sum[SAMPLE_W+7:8];

    // Window bookkeeping at the end of a sample
    assign push_go    = !(last_reg && m_valid_reg && !m_axis_tready);
    assign hist_push  = (state_reg == ST_PUSH) && push_go;
    assign hist_clr   = hist_push && last_reg;
    assign win_err    = idx_reg < IW'(LAG + 1);
    assign tally_next = (sig_reg == SIG_POS && prev_sig_reg == SIG_NONE &&
                         tally_reg != TALLY_MAX) ? tally_reg + 1'b1 : tally_reg;

    // Multiplier operand select per step
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_SUM:
            begin
                mul_a = MW'(hist_rd);
                mul_b = MW'(hist_rd);
            end
            ST_SQ_S:
            begin
                mul_a = MW'(s_acc_reg);
                mul_b = MW'(s_acc_reg);
            end
            ST_SQ_T:
            begin
                mul_a = $signed(MW'(thr_reg));
                mul_b = $signed(MW'(thr_reg));
            end
            ST_SQ_D:
            begin
                mul_a = $signed(MW'(ad));
                mul_b = $signed(MW'(ad));
            end
            ST_R_LO:
            begin
                mul_a = $signed(MW'(t2_reg));
                mul_b = $signed(MW'(v_reg[HW-1:0]));
            end
            ST_R_HI:
            begin
                mul_a = $signed(MW'(t2_reg));
                mul_b = $signed(MW'(v_reg[VW-1:HW]));
            end
            ST_DECIDE:
            begin
                mul_a = $signed(MW'(infl_eff));
                mul_b = MW'(x_reg);
            end
            ST_MIX:
            begin
                mul_a = $signed(MW'(infl_cmp));
                mul_b = MW'(hist_newest);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Sequencer, accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            x_reg        <= '0;
            last_reg     <= 1'b0;
            off_reg      <= '0;
            k_reg        <= '0;
            s_acc_reg    <= '0;
            q_acc_reg    <= '0;
            d_reg        <= '0;
            v_reg        <= '0;
            t2_reg       <= '0;
            lhs_reg      <= '0;
            rhs_reg      <= '0;
            mix_reg      <= '0;
            sig_reg      <= SIG_NONE;
            prev_sig_reg <= SIG_NONE;
            tally_reg    <= '0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
            m_count_reg  <= '0;
            m_err_reg    <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        x_reg     <= $signed(s_axis_tdata);
                        last_reg  <= s_axis_tlast;
                        sig_reg   <= SIG_NONE;
                        k_reg     <= '0;
                        s_acc_reg <= '0;
                        q_acc_reg <= '0;
                        off_reg   <= (idx_reg == IW'(LAG)) ? '0 : LAGW'(1);
                        if (idx_reg < IW'(LAG))
                        begin
                            state_reg <= ST_PUSH;
                        end
                        else
                        begin
                            state_reg <= ST_SUM;
                        end
                    end
                end
                // Sum and sum of squares over LAG history entries
                ST_SUM:
                begin
                    s_acc_reg <= s_acc_reg + SUMW'(hist_rd);
                    if (k_reg != '0)
                    begin
                        q_acc_reg <= q_acc_reg + QW'(prod[SQW-1:0]);
                    end
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == LAGW'(LAG - 1))
                    begin
                        state_reg <= ST_SQ_S;
                    end
                end
                ST_SQ_S:
                begin
                    q_acc_reg <= q_acc_reg + QW'(prod[SQW-1:0]);
                    d_reg     <= lagx - DW'(s_acc_reg);
                    state_reg <= ST_SQ_T;
                end
                ST_SQ_T:
                begin
                    v_reg     <= v_clamp;
                    state_reg <= ST_SQ_D;
                end
                ST_SQ_D:
                begin
                    t2_reg    <= prod[T2W-1:0];
                    state_reg <= ST_R_LO;
                end
                ST_R_LO:
                begin
                    lhs_reg   <= CW'(prod[2*(DW-1)-1:0]) << 8;
                    state_reg <= ST_R_HI;
                end
                ST_R_HI:
                begin
                    rhs_reg   <= CW'(prod[T2W+HW-1:0]);
                    state_reg <= ST_DECIDE;
                end
                // Variance test and sign of the deviation
                ST_DECIDE:
                begin
                    if (sig_hit)
                    begin
                        sig_reg   <= d_reg[DW-1] ? SIG_NEG : SIG_POS;
                        state_reg <= ST_MIX;
                    end
                    else
                    begin
                        sig_reg   <= SIG_NONE;
                        state_reg <= ST_PUSH;
                    end
                end
                ST_MIX:
                begin
                    mix_reg   <= prod[MXW-1:0];
                    state_reg <= ST_PUSH;
                end
                // Commit sample; emit result at window end
                ST_PUSH:
                begin
                    if (push_go)
                    begin
                        state_reg <= ST_IDLE;
                        if (last_reg)
                        begin
                            m_valid_reg  <= 1'b1;
                            m_count_reg  <= win_err ? '0 : tally_next;
                            m_err_reg    <= win_err;
                            idx_reg      <= '0;
                            tally_reg    <= '0;
                            prev_sig_reg <= SIG_NONE;
                        end
                        else
                        begin
                            tally_reg    <= tally_next;
                            prev_sig_reg <= sig_reg;
                            if (idx_reg < IW'(MAX_SAMPLES))
                            begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(m_count_reg);
    assign m_axis_tuser  = m_err_reg;

    // A result only appears after a window-end sample commits
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_PUSH && last_reg))
        else $error("result raised without a window end");

    // A short window reports a zero count
    a_error_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("window error with nonzero count");

    // History tap stays inside the shift line during the sum
    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (rd_idx <= LAGW'(LAG)))
        else $error("history tap out of range");

    // Mix product holds while the commit stalls
    a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH && $past(state_reg == ST_PUSH)) |-> $stable(prod))
        else $error("product changed during commit stall");

endmodule

// ===== tb/tb_zscore_peak_counter_unit.sv =====
// tb_zscore_peak_counter_unit: self-checking testbench for the z-score peak counter.
// Drives windows of samples and register writes, predicts each window's peak count.
// Depends on zpc_pkg and zscore_peak_counter_unit.

module tb_zscore_peak_counter_unit
    import zpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int WIN_LAG      = LAG_DEFAULT;
    localparam int WIN_MAX      = MAX_SAMPLES_DEFAULT;
    localparam int HIST_N       = WIN_LAG + 1;
    localparam int SETTLE       = 30;
    localparam int STALL_LIMIT  = 4000;
    localparam int LONG_HOLD    = 600;
    localparam int RANDOM_ITEMS = 560;
    localparam int MIN_WINDOWS  = 16;
    localparam int PHASE_ITEMS  = 100;
    localparam int TRAIN_LEN    = 260;

    localparam logic [SAMPLE_W-1:0] SAMPLE_POS_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_MAX = 16'h8000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                is_last;
    } sample_beat_t;

    typedef struct packed {
        logic [TALLY_W-1:0] peak_count;
        logic               window_error;
    } tally_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [SAMPLE_W-1:0]    s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Stimulus and expectation stores
    sample_beat_t  pending_samples[$];
    tally_result_t expected_tallies[$];
    int            samples_queued = 0;
    int            samples_taken = 0;
    int            error_count = 0;

    // Handshake flags seen at the last rising edge
    logic s_fire = 1'b0;
    logic m_fire = 1'b0;

    // Predictor state and registers
    logic signed [SAMPLE_W-1:0] flt_hist [HIST_N];
    int                         win_index;
    logic [1:0]                 last_sig;
    logic [TALLY_W-1:0]         peak_tally;
    logic [THR_W-1:0]           thr_q4;
    logic [INFL_W-1:0]          infl_q8;
    logic [MDEV_W-1:0]          min_dev;

    // Sender and receiver pacing
    int   tx_gap = 0;
    int   tx_calm = 0;
    int   rx_gap = 0;
    int   rx_calm = 0;
    int   rx_hold = 0;
    logic rx_long_hold_req = 1'b0;
    logic rx_long_hold_done = 1'b0;
    int   stall_cycles = 0;

    zscore_peak_counter_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void push_hist(input logic signed [SAMPLE_W-1:0] v);
        for (int k = HIST_N - 1; k > 0; k--)
            flt_hist[k] = flt_hist[k - 1];
        flt_hist[0] = v;
    endfunction

    function automatic void clear_window();
        for (int k = 0; k < HIST_N; k++)
            flt_hist[k] = '0;
        win_index  = 0;
        last_sig   = SIG_NONE;
        peak_tally = '0;
    endfunction

    function automatic void reset_predictor();
        thr_q4  = THR_RESET;
        infl_q8 = INFL_RESET;
        min_dev = MDEV_RESET;
        clear_window();
    endfunction

    // One sample through the z-score test; a window end yields a tally
    function automatic void predict_sample(input logic signed [SAMPLE_W-1:0] x,
                                           input logic is_last);
        longint                     s_sum, q_sum, w, dev, var_est, abs_dev;
        longint                     lhs, rhs, infl, mix;
        logic signed [SAMPLE_W-1:0] nv;
        logic [1:0]                 sig;
        int                         base, start_idx;
        tally_result_t              res;
        start_idx = win_index;
        if (win_index < WIN_LAG) begin
            push_hist(x);
        end
        else begin
            // window of filtered values lags by one sample past the seed
            base  = (win_index == WIN_LAG) ? 0 : 1;
            s_sum = 0;
            q_sum = 0;
            for (int k = 0; k < WIN_LAG; k++) begin
                w = flt_hist[base + k];
                s_sum += w;
                q_sum += w * w;
            end
            dev     = WIN_LAG * longint'(x) - s_sum;
            var_est = WIN_LAG * q_sum - s_sum * s_sum;
            if (var_est < 0)
                var_est = 0;
            abs_dev = (dev < 0) ? -dev : dev;
            lhs     = 256 * abs_dev * abs_dev;
            rhs     = longint'(thr_q4) * longint'(thr_q4) * var_est;
            infl    = (infl_q8 > INFL_MAX) ? 256 : longint'(infl_q8);
            sig     = SIG_NONE;
            nv      = x;
            if (abs_dev > WIN_LAG * longint'(min_dev) && lhs > rhs) begin
                if (dev > 0) begin
                    sig = SIG_POS;
                    if (last_sig == SIG_NONE && peak_tally != TALLY_MAX)
                        peak_tally++;
                end
                else begin
                    sig = SIG_NEG;
                end
                // floor of the weighted mix
                mix = infl * longint'(x) + (256 - infl) * longint'(flt_hist[0]);
                nv  = SAMPLE_W'(mix >>> 8);
            end
            last_sig = sig;
            push_hist(nv);
        end
        if (win_index < WIN_MAX)
            win_index++;
        if (is_last) begin
            res.window_error = (start_idx < WIN_LAG + 1);
            res.peak_count   = res.window_error ? '0 : peak_tally;
            expected_tallies.push_back(res);
            clear_window();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_beat(input logic [SAMPLE_W-1:0] s, input logic l);
        sample_beat_t beat;
        beat.sample  = s;
        beat.is_last = l;
        pending_samples.push_back(beat);
        samples_queued++;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(16, 4);
        return $urandom_range(80, 20);
    endfunction

    // Sensor-like sample: level plus jitter, occasional spikes, some raw noise
    function automatic logic [SAMPLE_W-1:0] window_sample(input int level, input int jitter);
        int v;
        if ($urandom_range(99) < 8)
            return SAMPLE_W'($urandom);
        v = level + int'($urandom_range(2 * jitter)) - jitter;
        if ($urandom_range(99) < 10)
            v += ($urandom_range(1) ? 1 : -1) * int'($urandom_range(20000, 1500));
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return SAMPLE_W'(v);
    endfunction

    function automatic int queue_random_window();
        int len, level, jitter, r;
        r = $urandom_range(99);
        if (r < 8)
            len = $urandom_range(WIN_LAG + 1, 1);
        else if (r < 14)
            len = $urandom_range(WIN_LAG + 3, WIN_LAG + 2);
        else if (r < 90)
            len = $urandom_range(30, 8);
        else
            len = $urandom_range(150, 31);
        level  = int'($urandom_range(16000)) - 8000;
        jitter = $urandom_range(1) ? int'($urandom_range(60)) : int'($urandom_range(1500));
        for (int i = 0; i < len; i++)
            queue_beat(window_sample(level, jitter), i == len - 1);
        return len;
    endfunction

    task automatic write_setting(input logic [CFG_ADDR_W-1:0] addr, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(input int thr, input int infl, input int mdev);
        write_setting(CFG_THRESHOLD, thr);
        write_setting(CFG_INFLUENCE, infl);
        write_setting(CFG_MIN_DEV, mdev);
    endtask

    // Wait until every queued sample is taken and every tally has come back
    task automatic drain_results();
        do
            @(negedge clk);
        while (samples_taken != samples_queued || expected_tallies.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sample driver
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        sample_beat_t beat;
        if (!s_axis_tvalid || s_fire) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_samples.size() > 0) begin
                beat = pending_samples.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= beat.sample;
                s_axis_tlast  <= beat.is_last;
                if (tx_calm > 0) begin
                    tx_calm--;
                    tx_gap = 0;
                end
                else begin
                    if ($urandom_range(39) == 0)
                        tx_calm = $urandom_range(60, 20);
                    tx_gap = pick_gap();
                end
            end
            else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random back-pressure plus one long hold
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rx_long_hold_req && !rx_long_hold_done) begin
            rx_long_hold_done = 1'b1;
            rx_hold = LONG_HOLD;
        end
        if (m_fire) begin
            if (rx_calm > 0) begin
                rx_calm--;
                rx_gap = 0;
            end
            else begin
                if ($urandom_range(39) == 0)
                    rx_calm = $urandom_range(60, 20);
                rx_gap = pick_gap();
            end
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: register writes, sample prediction, result check
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        tally_result_t want;
        s_fire <= rst_n && s_axis_tvalid && s_axis_tready;
        m_fire <= rst_n && m_axis_tvalid && m_axis_tready;
        if (rst_n && cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_THRESHOLD: thr_q4  = cfg_data[THR_W-1:0];
                CFG_INFLUENCE: infl_q8 = cfg_data[INFL_W-1:0];
                CFG_MIN_DEV:   min_dev = cfg_data[MDEV_W-1:0];
                default: ;
            endcase
        end
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_sample(s_axis_tdata, s_axis_tlast);
            samples_taken++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_tallies.size() == 0) begin
                $display("%0t: result with none pending: tdata=%h tuser=%b",
                         $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else begin
                want = expected_tallies.pop_front();
                if (m_axis_tdata !== OUT_TDATA_W'(want.peak_count)) begin
                    $display("%0t: peak_count mismatch: expected %0d, actual %0d (tdata=%h)",
                             $time, want.peak_count, m_axis_tdata[TALLY_W-1:0], m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== want.window_error) begin
                    $display("%0t: window_error mismatch: expected %b, actual %b",
                             $time, want.window_error, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long with no transaction on any channel
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int phase_no;
        int phase_items;
        int random_items;
        int random_windows;
        phase_no       = 0;
        random_items   = 0;
        random_windows = 0;
        reset_predictor();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed windows at reset settings
        // single sample: short window
        queue_beat(SAMPLE_POS_MAX, 1'b1);
        // LAG+1 samples: still short, extremes of the sample range
        repeat (WIN_LAG) queue_beat(SAMPLE_NEG_MAX, 1'b0);
        queue_beat(SAMPLE_POS_MAX, 1'b1);
        // shortest counted window with one positive peak
        repeat (WIN_LAG) queue_beat('0, 1'b0);
        queue_beat(SAMPLE_POS_MAX, 1'b0);
        queue_beat('0, 1'b1);
        // negative signal then positive: not a new peak
        repeat (WIN_LAG) queue_beat('0, 1'b0);
        queue_beat(SAMPLE_NEG_MAX, 1'b0);
        queue_beat(SAMPLE_POS_MAX, 1'b0);
        queue_beat(16'h0001, 1'b1);
        // receiver holds off once while the sender keeps offering
        rx_long_hold_req = 1'b1;
        drain_results();

        // Peak train: one peak every two samples in one long window.
        // Zero influence keeps the history flat.
        apply_config($urandom_range(255), 0, 0);
        @(posedge clk);
        repeat (WIN_LAG) queue_beat('0, 1'b0);
        for (int i = 0; i < TRAIN_LEN; i++)
            queue_beat((i % 2) ? '0 : SAMPLE_W'($urandom_range(32767, 1)), i == TRAIN_LEN - 1);
        drain_results();

        // Random windows, a fresh register setting per phase
        while (random_items < RANDOM_ITEMS || random_windows < MIN_WINDOWS) begin
            case (phase_no)
                0: apply_config(0, 0, 0);
                1: apply_config(255, 511, 32767);
                2: apply_config(THR_RESET, INFL_RESET, MDEV_RESET);
                3: apply_config($urandom_range(64, 12), 256, $urandom_range(300));
                default:
                    apply_config($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(64, 12),
                                 $urandom_range(3) == 0 ? $urandom_range(511, 257)
                                                        : $urandom_range(256),
                                 $urandom_range(9) == 0 ? $urandom_range(32767)
                                                        : $urandom_range(600));
            endcase
            @(posedge clk);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                phase_items += queue_random_window();
                random_windows++;
            end
            random_items += phase_items;
            drain_results();
            phase_no++;
        end

        if (error_count == 0 && expected_tallies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/zpc_pkg.sv
hw/rtl/zpc_mul.sv
hw/rtl/zpc_hist.sv
hw/rtl/zscore_peak_counter_unit.sv
tb/tb_zscore_peak_counter_unit.sv
